@@ sv/lcg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Lexicographic combination generator package
// Shared widths, register indexes, reset values and controller/datapath types.
// ----------------------------------------------------------------------------
package lcg_pkg;

  localparam int unsigned MAX_CHOSEN_DEF   = 8;
  localparam int unsigned MAX_SET_SIZE_DEF = 63;

  localparam int unsigned TOTAL_W    = 6;
  localparam int unsigned CHOSEN_W   = 4;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned SUM_W      = SLOT_W + 1;
  localparam int unsigned POS_W      = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_ITEMS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHOSEN_COUNT = 2'd1;

  localparam logic [TOTAL_W-1:0]  TOTAL_RST  = 6'd8;
  localparam logic [CHOSEN_W-1:0] CHOSEN_RST = 4'd3;

  // Controller to datapath
  typedef struct packed {
    logic start;     // request accepted this cycle
    logic load_out;  // load next result into output register
    logic inc;       // step to next element
    logic advance;   // move to successor combination
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;      // enumeration exhausted
    logic last;      // current element is the final one
    logic out_free;  // output register can take a result
  } sts_t;

endpackage
`default_nettype wire

@@ sv/lcg_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Lexicographic combination generator controller
// Sequences accept, per-element emission and the successor step.
// ----------------------------------------------------------------------------
module lcg_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire lcg_pkg::sts_t sts_i,
  output lcg_pkg::cmd_t      cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EMIT = 2'd1;
  localparam logic [1:0] ST_ADV  = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (sts_i.done) begin
            state_d = ST_IDLE;
          end else if (sts_i.last) begin
            state_d = ST_ADV;
          end else begin
            cmd_o.inc = 1'b1;
          end
        end
      end
      ST_ADV: begin
        cmd_o.advance = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ sv/lcg_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Lexicographic combination generator datapath
// Slot lanes, exhausted flag, element counter, successor logic, output register.
// ----------------------------------------------------------------------------
module lcg_dpath #(
  parameter int unsigned MAX_CHOSEN   = lcg_pkg::MAX_CHOSEN_DEF,
  parameter int unsigned MAX_SET_SIZE = lcg_pkg::MAX_SET_SIZE_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire lcg_pkg::cmd_t                cmd_i,
  output lcg_pkg::sts_t                     sts_o,
  input  wire logic                         restart_i,
  input  wire logic [lcg_pkg::TOTAL_W-1:0]  total_items_i,
  input  wire logic [lcg_pkg::CHOSEN_W-1:0] chosen_count_i,
  input  wire logic                         out_ready_i,
  output logic                              out_valid_o,
  output logic [lcg_pkg::SLOT_W-1:0]        element_o,
  output logic [lcg_pkg::POS_W-1:0]         position_o,
  output logic                              last_in_run_o,
  output logic                              exhausted_o
);

  localparam int unsigned IDX_W = (MAX_CHOSEN > 1) ? $clog2(MAX_CHOSEN) : 1;
  localparam int unsigned CNT_W = IDX_W + 1;

  logic [lcg_pkg::SLOT_W-1:0]  slot_q [MAX_CHOSEN];
  logic [lcg_pkg::SLOT_W-1:0]  slot_d [MAX_CHOSEN];
  logic                        done_q, done_d;
  logic [IDX_W-1:0]            cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d;
  logic [lcg_pkg::SLOT_W-1:0]  element_q;
  logic [lcg_pkg::POS_W-1:0]   position_q;
  logic                        last_q, exh_q;

  logic [lcg_pkg::TOTAL_W-1:0] n_eff;
  logic                        bad_k;
  logic                        last_elem;
  logic [lcg_pkg::SLOT_W-1:0]  cur_slot;
  logic                        bump_ok;
  logic                        gap_found;
  logic [IDX_W-1:0]            pivot;
  logic [lcg_pkg::SLOT_W-1:0]  pivot_val;

  // Clamp set size, check k
  always_comb begin
    if (32'(total_items_i) > MAX_SET_SIZE) begin
      n_eff = lcg_pkg::TOTAL_W'(MAX_SET_SIZE);
    end else begin
      n_eff = total_items_i;
    end
    bad_k = (chosen_count_i == '0) ||
            (lcg_pkg::TOTAL_W'(chosen_count_i) > n_eff) ||
            (32'(chosen_count_i) > MAX_CHOSEN);
  end

  assign cur_slot  = slot_q[cnt_q];
  assign last_elem = ((CNT_W'(cnt_q) + CNT_W'(1)) == CNT_W'(chosen_count_i));

  // Successor search over the lanes
  always_comb begin
    bump_ok   = 1'b0;
    gap_found = 1'b0;
    pivot     = '0;
    pivot_val = '0;
    for (int j = 0; j < MAX_CHOSEN; j++) begin
      if (((5'(j) + 5'd1) == 5'(chosen_count_i)) &&
          ((lcg_pkg::SUM_W'(slot_q[j]) + lcg_pkg::SUM_W'(1)) <
           lcg_pkg::SUM_W'(n_eff))) begin
        bump_ok = 1'b1;
      end
    end
    // rightmost gap wins
    for (int j = 1; j < MAX_CHOSEN; j++) begin
      if ((5'(j) < 5'(chosen_count_i)) &&
          (lcg_pkg::SUM_W'(slot_q[j]) >
           (lcg_pkg::SUM_W'(slot_q[j-1]) + lcg_pkg::SUM_W'(1)))) begin
        gap_found = 1'b1;
        pivot     = IDX_W'(j - 1);
      end
    end
    for (int j = 0; j < MAX_CHOSEN; j++) begin
      if (IDX_W'(j) == pivot) begin
        pivot_val = slot_q[j];
      end
    end
  end

  always_comb begin
    slot_d = slot_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    if (cmd_i.start) begin
      cnt_d = '0;
      if (restart_i) begin
        for (int j = 0; j < MAX_CHOSEN; j++) begin
          slot_d[j] = lcg_pkg::SLOT_W'(j);
        end
        done_d = bad_k;
      end else begin
        done_d = done_q | bad_k;
      end
    end else if (cmd_i.inc) begin
      cnt_d = cnt_q + IDX_W'(1);
    end else if (cmd_i.advance) begin
      if (bump_ok) begin
        for (int j = 0; j < MAX_CHOSEN; j++) begin
          if ((5'(j) + 5'd1) == 5'(chosen_count_i)) begin
            slot_d[j] = slot_q[j] + lcg_pkg::SLOT_W'(1);
          end
        end
      end else if (gap_found) begin
        // bump the pivot, refill the tail consecutively
        for (int j = 0; j < MAX_CHOSEN; j++) begin
          if ((IDX_W'(j) >= pivot) && (5'(j) < 5'(chosen_count_i))) begin
            slot_d[j] = pivot_val + lcg_pkg::SLOT_W'(1) + lcg_pkg::SLOT_W'(j) -
                        lcg_pkg::SLOT_W'(pivot);
          end
        end
      end else begin
        done_d = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_CHOSEN; j++) begin
        slot_q[j] <= lcg_pkg::SLOT_W'(j);
      end
      done_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      slot_q      <= slot_d;
      done_q      <= done_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (done_q) begin
        element_q  <= '0;
        position_q <= '0;
        last_q     <= 1'b1;
        exh_q      <= 1'b1;
      end else begin
        element_q  <= cur_slot + lcg_pkg::SLOT_W'(1);
        position_q <= lcg_pkg::POS_W'(cnt_q);
        last_q     <= last_elem;
        exh_q      <= 1'b0;
      end
    end
  end

  assign sts_o.done     = done_q;
  assign sts_o.last     = last_elem;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign element_o     = element_q;
  assign position_o    = position_q;
  assign last_in_run_o = last_q;
  assign exhausted_o   = exh_q;

endmodule
`default_nettype wire

@@ sv/lexicographic_combination_generator.sv @@
// Sequence: a request is accepted in the idle state; the emit state then
//   registers its elements, one result per cycle while the output can take them,
//   and the advance state steps to the successor; no new request is taken until
//   then. An exhausted request emits one exhausted answer and returns to idle.
// Reset: asynchronous, active low; slots reload 0..MAX_CHOSEN-1, exhausted
//   clears, n = 8 and k = 3.
`default_nettype none
// ----------------------------------------------------------------------------
// Lexicographic combination generator
// Enumerates the k-subsets of {1..n} in lexicographic order, one element per
// output transfer, with a controller sequencing a lane-parallel datapath.
// ----------------------------------------------------------------------------
module lexicographic_combination_generator #(
  parameter int unsigned MAX_CHOSEN   = lcg_pkg::MAX_CHOSEN_DEF,
  parameter int unsigned MAX_SET_SIZE = lcg_pkg::MAX_SET_SIZE_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // request channel
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           restart_i,
  // result channel
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [lcg_pkg::SLOT_W-1:0]          element_o,
  output logic [lcg_pkg::POS_W-1:0]           position_o,
  output logic                                last_in_run_o,
  output logic                                exhausted_o,
  // register write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [lcg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [lcg_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic [lcg_pkg::TOTAL_W-1:0]  total_q, total_d;
  logic [lcg_pkg::CHOSEN_W-1:0] chosen_q, chosen_d;
  lcg_pkg::cmd_t                cmd;
  lcg_pkg::sts_t                sts;

  // Register writes are always taken; writes to unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    total_d  = total_q;
    chosen_d = chosen_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        lcg_pkg::REG_TOTAL_ITEMS: begin
          total_d = cfg_data_i[lcg_pkg::TOTAL_W-1:0];
        end
        lcg_pkg::REG_CHOSEN_COUNT: begin
          chosen_d = cfg_data_i[lcg_pkg::CHOSEN_W-1:0];
        end
        default: begin
          // ignore
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= lcg_pkg::TOTAL_RST;
      chosen_q <= lcg_pkg::CHOSEN_RST;
    end else begin
      total_q  <= total_d;
      chosen_q <= chosen_d;
    end
  end

  // Controller: accept, emit each element, then advance to the successor.
  lcg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: slot lanes, exhausted flag, successor logic and output register.
  lcg_dpath #(
    .MAX_CHOSEN   (MAX_CHOSEN),
    .MAX_SET_SIZE (MAX_SET_SIZE)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .restart_i      (restart_i),
    .total_items_i  (total_q),
    .chosen_count_i (chosen_q),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .element_o      (element_o),
    .position_o     (position_o),
    .last_in_run_o  (last_in_run_o),
    .exhausted_o    (exhausted_o)
  );

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// Combination generator testbench
// Drives requests and register writes into the generator, predicts every
// element of each k-subset (and the exhausted answers) with a behavioral
// scoreboard, and checks each output transfer against it under random stalls.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PICK_MAX      = lcg_pkg::MAX_CHOSEN_DEF;
  localparam int unsigned SET_MAX       = lcg_pkg::MAX_SET_SIZE_DEF;
  // Index space holds four registers; the upper two are unmapped
  localparam logic [lcg_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [lcg_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned REPORT_MAX    = 10;
  localparam int unsigned PHASE_ITEMS   = 50;

  // One output transfer: a single element of a combination
  typedef struct packed {
    logic [lcg_pkg::SLOT_W-1:0] element;
    logic [lcg_pkg::POS_W-1:0]  position;
    logic                       last_in_run;
    logic                       exhausted;
  } subset_elem_t;

  // Tracks the enumeration state and queues the elements each request must yield
  class combo_scoreboard;
    logic [lcg_pkg::TOTAL_W-1:0]  set_size;
    logic [lcg_pkg::CHOSEN_W-1:0] pick_count;
    logic [lcg_pkg::SLOT_W-1:0]   slots [PICK_MAX];
    bit                           exhausted_flag;
    subset_elem_t                 elems_due[$];
    int unsigned                  fail_count;

    function new();
      set_size   = lcg_pkg::TOTAL_RST;
      pick_count = lcg_pkg::CHOSEN_RST;
      fail_count = 0;
      reload_slots();
    endfunction

    // Load the first combination (zero-based) and leave the exhausted state
    function void reload_slots();
      for (int unsigned i = 0; i < PICK_MAX; i++) slots[i] = lcg_pkg::SLOT_W'(i);
      exhausted_flag = 1'b0;
    endfunction

    function void write_register(logic [lcg_pkg::CFG_IDX_W-1:0] idx,
                                 logic [lcg_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        lcg_pkg::REG_TOTAL_ITEMS: begin
          set_size = data[lcg_pkg::TOTAL_W-1:0];
        end
        lcg_pkg::REG_CHOSEN_COUNT: begin
          pick_count = data[lcg_pkg::CHOSEN_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void note_request(bit restart);
      int unsigned  n;
      int unsigned  k;
      int unsigned  p;
      subset_elem_t e;
      n = 32'(set_size);
      if (n > SET_MAX) n = SET_MAX;
      k = 32'(pick_count);
      if (restart) reload_slots();
      if (k == 0 || k > n || k > PICK_MAX) exhausted_flag = 1'b1;
      if (exhausted_flag) begin
        e.element     = '0;
        e.position    = '0;
        e.last_in_run = 1'b1;
        e.exhausted   = 1'b1;
        elems_due.insert(elems_due.size(), e);
        return;
      end
      for (int unsigned i = 0; i < k; i++) begin
        e.element     = lcg_pkg::SLOT_W'(slots[i] + 1'b1);
        e.position    = lcg_pkg::POS_W'(i);
        e.last_in_run = (i + 1 == k);
        e.exhausted   = 1'b0;
        elems_due.insert(elems_due.size(), e);
      end
      // Step to the successor; comparisons are done at full width, stores wrap
      if (slots[k-1] + 1 < n) begin
        slots[k-1] = slots[k-1] + 1'b1;
      end else begin
        p = k - 1;
        while (p > 0 && slots[p] <= slots[p-1] + 1) p--;
        if (p == 0) begin
          exhausted_flag = 1'b1;
        end else begin
          slots[p-1] = slots[p-1] + 1'b1;
          for (int unsigned i = p; i < k; i++) slots[i] = slots[i-1] + 1'b1;
        end
      end
    endfunction

    function void check_result(subset_elem_t got);
      subset_elem_t want;
      if (elems_due.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("[%0t] unexpected result: element %0d position %0d last %0b exhausted %0b",
                   $time, got.element, got.position, got.last_in_run, got.exhausted);
        return;
      end
      want = elems_due.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
          $write("[%0t] mismatch: expected element %0d position %0d last %0b exhausted %0b,",
                 $time, want.element, want.position, want.last_in_run, want.exhausted);
          $display(" got element %0d position %0d last %0b exhausted %0b",
                   got.element, got.position, got.last_in_run, got.exhausted);
        end
      end
    endfunction

    function int unsigned pending();
      return elems_due.size();
    endfunction
  endclass

  // Block inputs: all known from time zero
  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           restart_i   = 1'b0;
  logic                           out_ready_i = 1'b0;
  logic                           cfg_valid_i = 1'b0;
  logic [lcg_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [lcg_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  logic                       in_ready_o;
  logic                       out_valid_o;
  logic [lcg_pkg::SLOT_W-1:0] element_o;
  logic [lcg_pkg::POS_W-1:0]  position_o;
  logic                       last_in_run_o;
  logic                       exhausted_o;
  logic                       cfg_ready_o;

  combo_scoreboard board = new();

  // Stall knobs, percent of cycles spent idle on each side
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  // Hold-off requests from the stimulus, taken up by the receiver process
  int unsigned hold_asked    = 0;
  int unsigned hold_taken    = 0;
  int unsigned hold_left     = 0;
  int unsigned requests_sent = 0;
  int unsigned cycle_count   = 0;

  lexicographic_combination_generator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .restart_i     (restart_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .element_o     (element_o),
    .position_o    (position_o),
    .last_in_run_o (last_in_run_o),
    .exhausted_o   (exhausted_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: end the run if the block stops making progress
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d elements still due", cycle_count, board.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Output monitor: check every result transfer at the rising edge
  always @(posedge clk_i) begin
    subset_elem_t seen;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.element     = element_o;
      seen.position    = position_o;
      seen.last_in_run = last_in_run_o;
      seen.exhausted   = exhausted_o;
      board.check_result(seen);
    end
  end

  // Result receiver: random back-pressure, or a long hold-off when asked for
  always @(negedge clk_i) begin
    if (hold_taken != hold_asked) begin
      hold_taken = hold_asked;
      hold_left  = HOLD_CYCLES;
    end
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one request; entered and left at a falling edge. Valid stays high
  // between back-to-back requests so it never drops and rises in one step.
  task automatic send_request(input bit restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(restart);
    requests_sent++;
    @(negedge clk_i);
  endtask

  // Drop the request channel and wait until every predicted element came out
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // One register transfer; valid is left high for a following write
  task automatic write_register(input logic [lcg_pkg::CFG_IDX_W-1:0] idx,
                                input logic [lcg_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_register(idx, data);
    @(negedge clk_i);
  endtask

  // Write n and k, with a stray write to an unmapped index first
  task automatic apply_settings(input logic [lcg_pkg::CFG_DATA_W-1:0] n_data,
                                input logic [lcg_pkg::CFG_DATA_W-1:0] k_data);
    write_register(($urandom_range(1) != 0) ? REG_SPARE_A : REG_SPARE_B,
                   lcg_pkg::CFG_DATA_W'($urandom));
    write_register(lcg_pkg::REG_TOTAL_ITEMS, n_data);
    write_register(lcg_pkg::REG_CHOSEN_COUNT, k_data);
    cfg_valid_i <= 1'b0;
  endtask

  // Reconfigure while idle, then walk the enumeration with occasional restarts
  task automatic run_segment(input int unsigned n, input int unsigned k,
                             input int unsigned len, input bit fresh);
    drain();
    apply_settings(lcg_pkg::CFG_DATA_W'(n), {2'($urandom), 4'(k)});
    for (int unsigned i = 0; i < len; i++)
      send_request((i == 0) ? fresh : ($urandom_range(15) == 0));
  endtask

  initial begin
    int unsigned n;
    int unsigned k;
    int unsigned len;
    int unsigned sel;
    int unsigned phase_end;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset state with n = 8, k = 3, no restart
    send_request(1'b0);
    send_request(1'b0);

    // k equal to n: one combination, then exhausted twice, then restart revives it
    drain();
    apply_settings(6'd4, 6'd4);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);

    // Largest set and largest k, all data bits high on the n write
    drain();
    apply_settings(6'd63, 6'd8);
    send_request(1'b1);
    send_request(1'b0);

    // Unusable k: zero, masked to 15, above the lane count, and an empty set
    drain();
    apply_settings(6'd5, 6'd0);
    send_request(1'b1);
    drain();
    apply_settings(6'd5, 6'h3F);
    send_request(1'b0);
    drain();
    apply_settings(6'd20, 6'd9);
    send_request(1'b1);
    drain();
    apply_settings(6'd0, 6'd1);
    send_request(1'b1);

    // Single-element set: one answer, then exhausted
    drain();
    apply_settings(6'd1, 6'd1);
    send_request(1'b1);
    send_request(1'b0);

    // Widen k without a restart: stale slots are used as they stand
    drain();
    apply_settings(6'd6, 6'd2);
    send_request(1'b1);
    send_request(1'b0);
    drain();
    apply_settings(6'd6, 6'd4);
    send_request(1'b0);
    send_request(1'b0);

    // Random phases: sender-light/receiver-heavy stalls, swapped, then none
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 25;
          recv_idle_pct = 85;
        end
        1: begin
          send_idle_pct = 85;
          recv_idle_pct = 25;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      if (ph == 2) begin
        // Hold the output off while requests keep coming, so the input stalls
        drain();
        apply_settings(6'd7, 6'd5);
        hold_asked++;
        repeat (14) send_request(1'b1);
        // Walk a single-element enumeration up to the top value and past it
        run_segment(63, 1, 66, 1'b1);
      end

      phase_end = requests_sent + PHASE_ITEMS;
      while (requests_sent < phase_end) begin
        sel = $urandom_range(9);
        if (sel == 0) begin
          // Unusable k against any n
          n   = $urandom_range(63);
          k   = ($urandom_range(1) != 0) ? 0 : $urandom_range(9, 15);
          len = $urandom_range(2, 4);
        end else if (sel == 1) begin
          // Large set: few requests, deep into the element range
          n   = $urandom_range(8, 63);
          k   = $urandom_range(1, PICK_MAX);
          len = $urandom_range(3, 10);
        end else begin
          // Small set: may run to exhaustion, k may exceed n by one
          n   = $urandom_range(1, PICK_MAX);
          k   = $urandom_range(1, (n < PICK_MAX) ? n + 1 : PICK_MAX);
          len = $urandom_range(4, 40);
        end
        run_segment(n, k, len, ($urandom_range(4) != 0));
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.fail_count == 0 && board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
